// ===== sv/cqir_pkg.sv =====
package cqir_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CNT_O_W = 5;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_READ    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } stat_t;

  // Commands from the controller to the datapath, valid for one cycle
  typedef struct packed {
    logic wr_tail;
    logic shift;
    logic inc;
    logic dec;
    logic clr;
    logic load_data;
    logic capture;
  } ctl_t;

  // Flags from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_ok;
  } sts_t;

endpackage

// ===== sv/cqir_ctrl.sv =====
module cqir_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_command,
  input  cqir_pkg::sts_t      sts,
  output cqir_pkg::ctl_t      ctl,
  output logic                busy,
  output logic                out_valid,
  output logic [1:0]          out_status
);
  import cqir_pkg::*;

  logic  accept;
  logic  valid_r, valid_nxt;
  stat_t status_r, status_nxt;
  cmd_t  cmd;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = cmd_t'(in_command);

  always_comb begin
    ctl        = '0;
    status_nxt = STAT_OK;
    ctl.capture = accept;
    unique case (cmd)
      CMD_ENQUEUE: begin
        if (sts.full) begin
          status_nxt = STAT_FULL;
        end else begin
          ctl.wr_tail = accept;
          ctl.inc     = accept;
        end
      end
      CMD_REMOVE, CMD_READ: begin
        priority if (sts.empty) begin
          status_nxt = STAT_EMPTY;
        end else if (!sts.idx_ok) begin
          status_nxt = STAT_RANGE;
        end else begin
          ctl.load_data = accept;
          if (cmd == CMD_REMOVE) begin
            ctl.shift = accept;
            ctl.dec   = accept;
          end
        end
      end
      CMD_CLEAR: begin
        ctl.clr = accept;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  assign valid_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Status is payload: hold it only when a beat is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat gave no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without an accepted beat");

  a_full_only_enq: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && $past(1'b1)) ##1 (out_status == STAT_FULL) |->
      ($past(in_command) == CMD_ENQUEUE))
    else $error("full status on a command other than enqueue");

  a_one_shift_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.inc, ctl.dec, ctl.clr}))
    else $error("conflicting count updates");

endmodule

// ===== sv/cqir_dp.sv =====
module cqir_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cqir_pkg::ctl_t               ctl,
  input  logic [cqir_pkg::VAL_W-1:0]   in_value,
  input  logic [cqir_pkg::IDX_W-1:0]   in_index,
  output cqir_pkg::sts_t               sts,
  output logic [cqir_pkg::VAL_W-1:0]   out_data,
  output logic [cqir_pkg::VAL_W-1:0]   out_head_value,
  output logic [cqir_pkg::CNT_O_W-1:0] out_entry_count
);
  import cqir_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WW = (CW > IDX_W) ? CW : IDX_W;

  logic [VAL_W-1:0] entries_r [DEPTH];
  logic [CW-1:0]    count_r, count_nxt;
  logic [VAL_W-1:0] data_r, data_nxt;
  logic [WW-1:0]    idx_w, cnt_w;
  logic [VAL_W-1:0] rd_val;

  assign idx_w  = WW'(in_index);
  assign cnt_w  = WW'(count_r);
  assign rd_val = entries_r[idx_w[AW-1:0]];

  assign sts.empty  = (count_r == '0);
  assign sts.full   = (count_r == CW'(DEPTH));
  assign sts.idx_ok = (idx_w < cnt_w);

  // Entries above the gap advance one place; the tail write lands at count
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctl.wr_tail && (count_r == CW'(k))) begin
        entries_r[k] <= in_value;
      end else if (ctl.shift && (WW'(k) >= idx_w)) begin
        if (k < DEPTH - 1) begin
          entries_r[k] <= entries_r[(k < DEPTH - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    priority if (ctl.clr) begin
      count_nxt = '0;
    end else if (ctl.inc) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign data_nxt = ctl.load_data ? rd_val : '0;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      data_r <= data_nxt;
    end
  end

  assign out_data        = data_r;
  assign out_head_value  = sts.empty ? '0 : entries_r[0];
  assign out_entry_count = CNT_O_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count beyond depth");

  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> (count_r == '0))
    else $error("clear left entries");

  a_inc_step: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.inc |=> (count_r == $past(count_r) + CW'(1)))
    else $error("enqueue did not add one entry");

  a_tail_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr_tail && sts.empty) |=> (out_head_value == $past(in_value)))
    else $error("enqueue to empty queue not at head");

endmodule

// ===== sv/collapsing_queue_with_indexed_remove.sv =====
// Channel  | Ports                                          | Handshake
// command  | in_command, in_value, in_index                 | start && !busy
// result   | out_data, out_status, out_head_value,          | out_valid, one cycle
//          | out_entry_count                                |
//
// One command per cycle: busy never rises, and every operation completes in
// one update of the register array (tail write or collapse).
// The result appears in the cycle after its command is taken, in order.
// rst_n (synchronous) empties the queue; stored values are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module collapsing_queue_with_indexed_remove #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [cqir_pkg::VAL_W-1:0]   in_value,
  input  logic [cqir_pkg::IDX_W-1:0]   in_index,
  output logic                         out_valid,
  output logic [cqir_pkg::VAL_W-1:0]   out_data,
  output logic [1:0]                   out_status,
  output logic [cqir_pkg::VAL_W-1:0]   out_head_value,
  output logic [cqir_pkg::CNT_O_W-1:0] out_entry_count
);
  import cqir_pkg::*;

  ctl_t ctl;
  sts_t sts;

  cqir_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  cqir_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_value        (in_value),
    .in_index        (in_index),
    .sts             (sts),
    .out_data        (out_data),
    .out_head_value  (out_head_value),
    .out_entry_count (out_entry_count)
  );

endmodule
